>>> sv/dag_pkg.sv
// ----------------------------------------------------------------------------
// dag_pkg
// shared types and constants of the distance attenuation gain pipeline
// ----------------------------------------------------------------------------
`default_nettype none
package dag_pkg;

  localparam int unsigned FieldW = 24;
  localparam int unsigned GainW  = 16;
  localparam int unsigned QuoW   = 16;
  localparam int unsigned NumW   = 40;
  localparam int unsigned LogW   = 22;

  localparam logic [GainW-1:0] UnityQ15 = 16'd32768;
  localparam logic [15:0]      Ln2Q16   = 16'd45426;

  typedef enum logic [1:0] {
    MODEL_LINEAR  = 2'd0,
    MODEL_INVERSE = 2'd1,
    MODEL_EXPO    = 2'd2,
    MODEL_CUSTOM  = 2'd3
  } model_t;

  typedef struct packed {
    logic              vld;
    logic              unity;
    logic [FieldW-1:0] den;
    logic [FieldW-1:0] rem;
    logic [QuoW-1:0]   low;
    logic [QuoW-1:0]   quo;
  } div_t;

  function automatic logic [16:0] log2_rom(input int unsigned idx, input int unsigned bits);
    longint unsigned x;
    longint unsigned acc;
    x   = (64'd1 << 30) + (longint'(idx) << (30 - bits));
    acc = 0;
    for (int k = 0; k < 17; k++) begin
      x   = (x * x) >> 30;
      acc = acc << 1;
      if (x >= (64'd1 << 31)) begin
        acc = acc | 64'd1;
        x   = x >> 1;
      end
    end
    return 17'((acc + 64'd1) >> 1);
  endfunction

endpackage
`default_nettype wire

>>> sv/dag_prep.sv
// ----------------------------------------------------------------------------
// dag_prep
// clamp, per-model numerator and divisor, log2 path of the custom curve
// ----------------------------------------------------------------------------
`default_nettype none
module dag_prep #(
  parameter int unsigned LOG_TABLE_BITS = 8
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_vld,
  input  wire  [dag_pkg::FieldW-1:0]    in_distance_q8,
  input  wire  [dag_pkg::FieldW-1:0]    in_near_limit_q8,
  input  wire  [dag_pkg::FieldW-1:0]    in_far_limit_q8,
  input  dag_pkg::model_t               model,
  output dag_pkg::div_t                 div_out
);
  import dag_pkg::*;

  localparam int unsigned TblN = 1 << LOG_TABLE_BITS;

  logic [16:0] rom [TblN];
  for (genvar g = 0; g < TblN; g++) begin : g_rom
    assign rom[g] = log2_rom(g, LOG_TABLE_BITS);
  end

  function automatic logic [LogW-1:0] log2_fx(input logic [FieldW-1:0] x,
                                              input logic [16:0] t [TblN]);
    logic [4:0]              e;
    logic [FieldW-1:0]       m;
    logic [LOG_TABLE_BITS-1:0] idx;
    e = 5'd0;
    for (int b = 1; b < FieldW; b++) begin
      if (x[b]) e = 5'(b);
    end
    m   = x << (5'(FieldW - 1) - e);
    idx = m[FieldW-2 -: LOG_TABLE_BITS];
    return {e, 16'b0} + LogW'(t[idx]);
  endfunction

  // stage 1
  logic              s1_vld_r, s1_unity_r;
  model_t            s1_model_r;
  logic [FieldW-1:0] s1_d_r, s1_lo_r, s1_hi_r;
  logic [FieldW-1:0] d_clamp;

  always_comb begin
    d_clamp = in_distance_q8;
    if (d_clamp < in_near_limit_q8) d_clamp = in_near_limit_q8;
    if (d_clamp > in_far_limit_q8) d_clamp = in_far_limit_q8;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
    s1_unity_r <= (in_near_limit_q8 == '0) || (in_near_limit_q8 >= in_far_limit_q8);
    s1_model_r <= model;
    s1_d_r     <= d_clamp;
    s1_lo_r    <= in_near_limit_q8;
    s1_hi_r    <= in_far_limit_q8;
  end

  // stage 2
  logic              s2_vld_r, s2_unity_r, s2_custom_r;
  logic [NumW-1:0]   s2_num_r, s2_num_nxt;
  logic [FieldW-1:0] s2_den_r, s2_den_nxt;
  logic [LogW-1:0]   s2_diff_r;
  logic [FieldW-1:0] span;

  always_comb begin
    span = s1_hi_r - s1_lo_r;
    unique case (s1_model_r)
      MODEL_LINEAR: begin
        s2_den_nxt = span;
        s2_num_nxt = (NumW'(s1_hi_r - s1_d_r) << 15) + NumW'(span >> 1);
      end
      default: begin
        s2_den_nxt = s1_d_r;
        s2_num_nxt = (NumW'(s1_lo_r) << 15) + NumW'(s1_d_r >> 1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_unity_r  <= s1_unity_r;
    s2_custom_r <= (s1_model_r == MODEL_CUSTOM);
    s2_num_r    <= s2_num_nxt;
    s2_den_r    <= s2_den_nxt;
    s2_diff_r   <= log2_fx(s1_d_r, rom) - log2_fx(s1_lo_r, rom);
  end

  // stage 3
  logic [LogW+15:0]  prod;
  logic [LogW-1:0]   ln_q16;
  logic [FieldW-1:0] den_c;

  always_comb begin
    prod   = LogW'(s2_diff_r) * (LogW + 16)'(Ln2Q16) + (LogW + 16)'(32768);
    ln_q16 = LogW'(prod >> 16);
    den_c  = FieldW'(131072) + FieldW'(ln_q16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_out.vld <= 1'b0;
    end else begin
      div_out.vld <= s2_vld_r;
    end
    div_out.unity <= s2_unity_r;
    if (s2_custom_r) begin
      div_out.den <= den_c;
      div_out.rem <= FieldW'((NumW'(1) << 32 | NumW'(den_c >> 1)) >> QuoW);
      div_out.low <= QuoW'(NumW'(den_c >> 1));
    end else begin
      div_out.den <= s2_den_r;
      div_out.rem <= FieldW'(s2_num_r >> QuoW);
      div_out.low <= s2_num_r[QuoW-1:0];
    end
    div_out.quo <= '0;
  end

endmodule
`default_nettype wire

>>> sv/dag_div_cell.sv
// ----------------------------------------------------------------------------
// dag_div_cell
// one restoring division step, one quotient bit per cell
// ----------------------------------------------------------------------------
`default_nettype none
module dag_div_cell (
  input  wire            clk,
  input  wire            rst_n,
  input  dag_pkg::div_t  cell_in,
  output dag_pkg::div_t  cell_out
);
  import dag_pkg::*;

  logic [FieldW:0] trial;
  logic            take;

  always_comb begin
    trial = {cell_in.rem, cell_in.low[QuoW-1]};
    take  = trial >= {1'b0, cell_in.den};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_out.vld <= 1'b0;
    end else begin
      cell_out.vld <= cell_in.vld;
    end
    cell_out.unity <= cell_in.unity;
    cell_out.den   <= cell_in.den;
    cell_out.rem   <= take ? FieldW'(trial - {1'b0, cell_in.den}) : FieldW'(trial);
    cell_out.low   <= cell_in.low << 1;
    cell_out.quo   <= {cell_in.quo[QuoW-2:0], take};
  end

endmodule
`default_nettype wire

>>> sv/distance_attenuation_gain.sv
// ----------------------------------------------------------------------------
// distance_attenuation_gain
// registered path from start to out_valid, one request per cycle
// three prep stages, a chain of 16 division cells, one output register
// busy is always low; the receiver cannot stall
// synchronous reset clears the valid chain and sets the model to inverse
// ----------------------------------------------------------------------------
`default_nettype none
module distance_attenuation_gain #(
  parameter int unsigned LOG_TABLE_BITS = 8
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  output logic                        busy,
  input  wire  [dag_pkg::FieldW-1:0]  in_distance_q8,
  input  wire  [dag_pkg::FieldW-1:0]  in_near_limit_q8,
  input  wire  [dag_pkg::FieldW-1:0]  in_far_limit_q8,
  output logic                        out_valid,
  output logic [dag_pkg::GainW-1:0]   out_gain_q15,
  input  wire                         cfg_we,
  input  wire  [1:0]                  cfg_wdata
);
  import dag_pkg::*;

  model_t model_r;
  div_t   chain [QuoW+1];
  logic   out_valid_r;
  logic [GainW-1:0] gain_r, gain_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      model_r <= MODEL_INVERSE;
    end else if (cfg_we) begin
      model_r <= model_t'(cfg_wdata);
    end
  end

  dag_prep #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_prep (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_vld           (start),
    .in_distance_q8   (in_distance_q8),
    .in_near_limit_q8 (in_near_limit_q8),
    .in_far_limit_q8  (in_far_limit_q8),
    .model            (model_r),
    .div_out          (chain[0])
  );

  for (genvar i = 0; i < QuoW; i++) begin : g_cell
    dag_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_in  (chain[i]),
      .cell_out (chain[i+1])
    );
  end

  always_comb begin
    if (chain[QuoW].unity || chain[QuoW].quo > UnityQ15) begin
      gain_nxt = UnityQ15;
    end else begin
      gain_nxt = chain[QuoW].quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain[QuoW].vld;
    end
    gain_r <= gain_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_gain_q15 = gain_r;

endmodule
`default_nettype wire
